// ----- rtl/ole_pkg.sv -----
// Shared constants, types and helpers of the ordered list engine.
`default_nettype none
package ole_pkg;

  localparam int Capacity = 16;
  localparam int IdxW     = (Capacity > 1) ? $clog2(Capacity) : 1;
  localparam int CntW     = $clog2(Capacity + 1);
  localparam int DataW    = 32;
  localparam int SizeW    = 5;

  typedef enum logic [2:0] {
    KIND_APPEND = 3'd0,
    KIND_HEAD   = 3'd1,
    KIND_SEARCH = 3'd2,
    KIND_REMOVE = 3'd3,
    KIND_READ   = 3'd4
  } kind_e;

  typedef enum logic [1:0] {
    STAT_DONE     = 2'd0,
    STAT_FULL     = 2'd1,
    STAT_NOTFOUND = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    CH_HOLD,
    CH_LOAD,
    CH_ROTL,
    CH_DROP,
    CH_SHR
  } chain_op_e;

  typedef struct packed {
    chain_op_e         op;
    logic [DataW-1:0]  inj;
  } chain_ctl_t;

  function automatic logic [SizeW-1:0] size_of(logic [CntW-1:0] c);
    logic [CntW+SizeW-1:0] e;
    e = {{SizeW{1'b0}}, c};
    return e[SizeW-1:0];
  endfunction

endpackage
`default_nettype wire

// ----- rtl/ole_cell.sv -----
// One list slot of the cell chain: holds an entry and shifts to either neighbor.
`default_nettype none
module ole_cell (
  input  logic                          clk_i,
  input  ole_pkg::chain_ctl_t           ctl_i,
  input  logic                          hit_i,
  input  logic [ole_pkg::DataW-1:0]     left_i,
  input  logic [ole_pkg::DataW-1:0]     right_i,
  output logic [ole_pkg::DataW-1:0]     data_o
);

  logic [ole_pkg::DataW-1:0] data_q, data_d;

  always_comb begin
    unique case (ctl_i.op)
      ole_pkg::CH_HOLD: data_d = data_q;
      ole_pkg::CH_LOAD: data_d = hit_i ? ctl_i.inj : data_q;
      ole_pkg::CH_ROTL: data_d = hit_i ? ctl_i.inj : right_i;
      ole_pkg::CH_DROP: data_d = right_i;
      ole_pkg::CH_SHR:  data_d = left_i;
      default:          data_d = data_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o = data_q;

endmodule
`default_nettype wire

// ----- rtl/ordered_list_engine_unit.sv -----
// Ordered list engine: sequencer and output register over a chain of list cells.
// Entries live in a row of cells; cell 0 is the front of the list and is the only
// place a value is compared or read out, so the list rotates through it. One command
// is taken at a time. Append and head insert finish in the accept cycle and give one
// result. Search and remove with N entries rotate each entry once through the cell 0
// comparator, then give one result (an empty list answers at once). Read out
// emits N beats, one per cycle while the output is taken, front to back straight
// from cell 0; back to front pre-rotates once in the accept cycle, so the tail is
// already in cell 0 for the first beat. A result waits in an output register; the next
// command is taken in the cycle that register frees.
`default_nettype none
module ordered_list_engine_unit (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [2:0]          kind_i,
  input  logic signed [31:0]  value_i,
  input  logic                backward_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [1:0]          status_o,
  output logic                found_o,
  output logic signed [31:0]  item_value_o,
  output logic [4:0]          size_o,
  output logic                last_o
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_READ
  } state_e;

  state_e                          state_q, state_d;
  logic [ole_pkg::CntW-1:0]        count_q, count_d;
  logic [ole_pkg::CntW-1:0]        step_q, step_d;
  logic [ole_pkg::DataW-1:0]       key_q, key_d;
  logic                            rm_q, rm_d;
  logic                            back_q, back_d;
  logic                            hitf_q, hitf_d;
  logic                            ov_q, ov_d;
  ole_pkg::status_e                stat_q, stat_d;
  logic                            fnd_q, fnd_d;
  logic [ole_pkg::DataW-1:0]       item_q, item_d;
  logic [ole_pkg::SizeW-1:0]       size_q, size_d;
  logic                            last_q, last_d;

  ole_pkg::chain_ctl_t             ctl;
  logic [ole_pkg::IdxW-1:0]        sel;
  logic [ole_pkg::Capacity-1:0]    hit;
  logic [ole_pkg::DataW-1:0]       cdata [ole_pkg::Capacity];
  logic [ole_pkg::DataW-1:0]       front, tail;
  logic                            out_free, accept, full, match, last_step;
  ole_pkg::kind_e                  kind;

  for (genvar g = 0; g < ole_pkg::Capacity; g++) begin : g_cells
    logic [ole_pkg::DataW-1:0] left_w, right_w;
    if (g == 0) begin : g_first
      assign left_w = ctl.inj;
    end else begin : g_mid
      assign left_w = cdata[g-1];
    end
    if (g == ole_pkg::Capacity - 1) begin : g_end
      assign right_w = '0;
    end else begin : g_body
      assign right_w = cdata[g+1];
    end
    assign hit[g] = (sel == ole_pkg::IdxW'(g));
    ole_cell u_cell (
      .clk_i   (clk_i),
      .ctl_i   (ctl),
      .hit_i   (hit[g]),
      .left_i  (left_w),
      .right_i (right_w),
      .data_o  (cdata[g])
    );
  end

  assign front     = cdata[0];
  assign tail      = cdata[ole_pkg::IdxW'(count_q - ole_pkg::CntW'(1))];
  assign out_free  = !ov_q || out_ready_i;
  assign in_ready_o = (state_q == ST_IDLE) && out_free;
  assign accept    = in_valid_i && in_ready_o;
  assign full      = (count_q == ole_pkg::CntW'(ole_pkg::Capacity));
  assign match     = (front == key_q) && !hitf_q;
  assign last_step = (step_q == ole_pkg::CntW'(1));
  assign kind      = ole_pkg::kind_e'(kind_i);

  always_comb begin
    state_d  = state_q;
    count_d  = count_q;
    step_d   = step_q;
    key_d    = key_q;
    rm_d     = rm_q;
    back_d   = back_q;
    hitf_d   = hitf_q;
    ov_d     = ov_q && !out_ready_i;
    stat_d   = stat_q;
    fnd_d    = fnd_q;
    item_d   = item_q;
    size_d   = size_q;
    last_d   = last_q;
    ctl.op   = ole_pkg::CH_HOLD;
    ctl.inj  = front;
    sel      = ole_pkg::IdxW'(count_q - ole_pkg::CntW'(1));

    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          ov_d   = 1'b1;
          stat_d = ole_pkg::STAT_DONE;
          fnd_d  = 1'b0;
          item_d = '0;
          last_d = 1'b1;
          size_d = ole_pkg::size_of(count_q);
          key_d  = $unsigned(value_i);
          back_d = backward_i;
          hitf_d = 1'b0;
          step_d = count_q;
          unique case (kind)
            ole_pkg::KIND_APPEND, ole_pkg::KIND_HEAD: begin
              if (full) begin
                stat_d = ole_pkg::STAT_FULL;
              end else begin
                ctl.inj = $unsigned(value_i);
                sel     = ole_pkg::IdxW'(count_q);
                ctl.op  = (kind == ole_pkg::KIND_APPEND) ? ole_pkg::CH_LOAD : ole_pkg::CH_SHR;
                count_d = count_q + ole_pkg::CntW'(1);
                size_d  = ole_pkg::size_of(count_d);
              end
            end
            ole_pkg::KIND_SEARCH, ole_pkg::KIND_REMOVE: begin
              rm_d = (kind == ole_pkg::KIND_REMOVE);
              if (count_q == '0) begin
                stat_d = ole_pkg::STAT_NOTFOUND;
              end else begin
                ov_d    = 1'b0;
                state_d = ST_SCAN;
              end
            end
            ole_pkg::KIND_READ: begin
              if (count_q == '0) begin
                stat_d = ole_pkg::STAT_NOTFOUND;
              end else begin
                ov_d    = 1'b0;
                state_d = ST_READ;
                if (backward_i) begin
                  ctl.op  = ole_pkg::CH_SHR;
                  ctl.inj = tail;
                end
              end
            end
            default: begin
            end
          endcase
        end
      end
      ST_SCAN: begin
        step_d = step_q - ole_pkg::CntW'(1);
        if (match) begin
          hitf_d = 1'b1;
        end
        if (match && rm_q) begin
          ctl.op  = ole_pkg::CH_DROP;
          count_d = count_q - ole_pkg::CntW'(1);
        end else begin
          ctl.op = ole_pkg::CH_ROTL;
        end
        if (last_step) begin
          state_d = ST_IDLE;
          ov_d    = 1'b1;
          fnd_d   = hitf_d;
          stat_d  = hitf_d ? ole_pkg::STAT_DONE : ole_pkg::STAT_NOTFOUND;
          item_d  = '0;
          last_d  = 1'b1;
          size_d  = ole_pkg::size_of(count_d);
        end
      end
      ST_READ: begin
        if (out_free) begin
          ov_d   = 1'b1;
          stat_d = ole_pkg::STAT_DONE;
          fnd_d  = 1'b0;
          item_d = front;
          last_d = last_step;
          size_d = ole_pkg::size_of(count_q);
          step_d = step_q - ole_pkg::CntW'(1);
          if (!back_q) begin
            ctl.op = ole_pkg::CH_ROTL;
          end else if (!last_step) begin
            ctl.op  = ole_pkg::CH_SHR;
            ctl.inj = tail;
          end
          if (last_step) begin
            state_d = ST_IDLE;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      count_q <= '0;
      step_q  <= '0;
      hitf_q  <= 1'b0;
      ov_q    <= 1'b0;
      rm_q    <= 1'b0;
      back_q  <= 1'b0;
      key_q   <= '0;
      stat_q  <= ole_pkg::STAT_DONE;
      fnd_q   <= 1'b0;
      item_q  <= '0;
      size_q  <= '0;
      last_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      step_q  <= step_d;
      hitf_q  <= hitf_d;
      ov_q    <= ov_d;
      rm_q    <= rm_d;
      back_q  <= back_d;
      key_q   <= key_d;
      stat_q  <= stat_d;
      fnd_q   <= fnd_d;
      item_q  <= item_d;
      size_q  <= size_d;
      last_q  <= last_d;
    end
  end

  assign out_valid_o  = ov_q;
  assign status_o     = stat_q;
  assign found_o      = fnd_q;
  assign item_value_o = $signed(item_q);
  assign size_o       = size_q;
  assign last_o       = last_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= ole_pkg::CntW'(ole_pkg::Capacity))
    else $error("entry count above capacity");

  a_scan_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCAN) |-> (count_q != '0) && (step_q != '0))
    else $error("scan running on empty list");

  a_run_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !last_o) |-> (state_q == ST_READ))
    else $error("open read-out run without sequencer in read state");

  a_append_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && (kind_i == ole_pkg::KIND_APPEND) && !full)
      |=> (count_q == $past(count_q) + ole_pkg::CntW'(1)))
    else $error("append did not grow the list");

endmodule
`default_nettype wire

// ----- test/testbench.sv -----
// Self-checking testbench for the ordered list engine: directed and random commands.
`timescale 1ns / 100ps
module testbench;
  import ole_pkg::*;

  localparam int StallLimit = 2000;
  localparam int TailCycles = 40;
  localparam int HoldCycles = 250;
  localparam int RandomItems = 300;

  typedef struct packed {
    logic [1:0]         status;
    logic               found;
    logic signed [31:0] item_value;
    logic [4:0]         size;
    logic               is_last;
  } list_beat_t;

  class list_scoreboard;
    logic signed [31:0] cells [Capacity];
    int unsigned        fill;
    list_beat_t         expected_q[$];
    int unsigned        mismatches;
    int unsigned        commands_seen;
    int unsigned        beats_checked;
    int unsigned        full_rejects;
    int unsigned        read_outs;
    int unsigned        peak_fill;

    function new();
      fill = 0;
      mismatches = 0;
      commands_seen = 0;
      beats_checked = 0;
      full_rejects = 0;
      read_outs = 0;
      peak_fill = 0;
    endfunction

    function void push_beat(logic [1:0] st, logic fnd, logic signed [31:0] val, logic lst);
      list_beat_t b;
      b.status = st;
      b.found = fnd;
      b.item_value = val;
      b.size = fill[4:0];
      b.is_last = lst;
      expected_q.push_back(b);
    endfunction

    function void note_command(logic [2:0] kind, logic signed [31:0] value, logic backward);
      int pos;
      int i;
      commands_seen++;
      case (kind)
        KIND_APPEND, KIND_HEAD: begin
          if (fill >= Capacity) begin
            full_rejects++;
            push_beat(STAT_FULL, 1'b0, '0, 1'b1);
          end else begin
            if (kind == KIND_HEAD) begin
              for (i = fill; i > 0; i--) cells[i] = cells[i-1];
              cells[0] = value;
            end else begin
              cells[fill] = value;
            end
            fill++;
            if (fill > peak_fill) peak_fill = fill;
            push_beat(STAT_DONE, 1'b0, '0, 1'b1);
          end
        end
        KIND_SEARCH, KIND_REMOVE: begin
          pos = -1;
          for (i = 0; i < fill; i++) begin
            if (pos < 0 && cells[i] == value) pos = i;
          end
          if (pos < 0) begin
            push_beat(STAT_NOTFOUND, 1'b0, '0, 1'b1);
          end else begin
            if (kind == KIND_REMOVE) begin
              for (i = pos; i + 1 < fill; i++) cells[i] = cells[i+1];
              fill--;
            end
            push_beat(STAT_DONE, 1'b1, '0, 1'b1);
          end
        end
        KIND_READ: begin
          read_outs++;
          if (fill == 0) begin
            push_beat(STAT_NOTFOUND, 1'b0, '0, 1'b1);
          end else begin
            for (i = 0; i < fill; i++) begin
              push_beat(STAT_DONE, 1'b0, cells[backward ? fill - 1 - i : i], i + 1 == fill);
            end
          end
        end
        default: begin
          push_beat(STAT_DONE, 1'b0, '0, 1'b1);
        end
      endcase
    endfunction

    function void check_beat(list_beat_t got);
      list_beat_t want;
      beats_checked++;
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("[%0t] unexpected beat: status=%0d found=%0d item=%0d size=%0d last=%0d",
                   $time, got.status, got.found, got.item_value, got.size,
                   got.is_last);
        return;
      end
      want = expected_q.pop_front();
      if (got.status !== want.status || got.found !== want.found ||
          got.item_value !== want.item_value || got.size !== want.size ||
          got.is_last !== want.is_last) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("[%0t] beat mismatch: expected status=%0d found=%0d item=%0d size=%0d last=%0d",
                   $time, want.status, want.found, want.item_value, want.size,
                   want.is_last);
          $display("[%0t]                     got status=%0d found=%0d item=%0d size=%0d last=%0d",
                   $time, got.status, got.found, got.item_value, got.size,
                   got.is_last);
        end
      end
    endfunction

    function int unsigned pending();
      return expected_q.size();
    endfunction
  endclass

  logic               clk_i;
  logic               rst_ni;
  logic               in_valid;
  logic               in_ready_o;
  logic [2:0]         kind;
  logic signed [31:0] value;
  logic               backward;
  logic               out_valid_o;
  logic               out_ready;
  logic [1:0]         status_o;
  logic               found_o;
  logic signed [31:0] item_value_o;
  logic [4:0]         size_o;
  logic               last_o;

  list_scoreboard board;
  bit             no_idle;
  int unsigned    stall_cycles;

  ordered_list_engine_unit dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid),
    .in_ready_o   (in_ready_o),
    .kind_i       (kind),
    .value_i      (value),
    .backward_i   (backward),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready),
    .status_o     (status_o),
    .found_o      (found_o),
    .item_value_o (item_value_o),
    .size_o       (size_o),
    .last_o       (last_o)
  );

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  function automatic int draw_gap();
    return no_idle ? 0 : $urandom_range(0, 11);
  endfunction

  // offer one command beat and hold it until taken
  task automatic send_command(input logic [2:0] k, input logic signed [31:0] v,
                              input logic b);
    int gap;
    gap = draw_gap();
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid = 1'b1;
    kind = k;
    value = v;
    backward = b;
    do @(posedge clk_i); while (!in_ready_o);
    board.note_command(k, v, b);
    @(negedge clk_i);
  endtask

  // result side: random stalls plus one long hold-off
  initial begin
    int gap;
    int unsigned taken;
    bit held;
    list_beat_t got;
    out_ready = 1'b0;
    taken = 0;
    held = 1'b0;
    @(posedge rst_ni);
    @(negedge clk_i);
    forever begin
      gap = draw_gap();
      if (!held && taken >= 60) begin
        held = 1'b1;
        gap = HoldCycles;
      end
      if (gap > 0) begin
        out_ready = 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      out_ready = 1'b1;
      do @(posedge clk_i); while (!out_valid_o);
      got.status = status_o;
      got.found = found_o;
      got.item_value = item_value_o;
      got.size = size_o;
      got.is_last = last_o;
      board.check_beat(got);
      taken++;
      @(negedge clk_i);
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid && in_ready_o) || (out_valid_o && out_ready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= StallLimit) begin
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  initial begin
    int n;
    int r;
    logic [2:0] k;
    logic signed [31:0] v;
    board = new();
    no_idle = 1'b0;
    stall_cycles = 0;
    rst_ni = 1'b0;
    in_valid = 1'b0;
    kind = KIND_APPEND;
    value = '0;
    backward = 1'b0;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // empty list cases
    send_command(KIND_READ, $urandom, 1'b0);
    send_command(KIND_SEARCH, 32'sd0, 1'b1);
    send_command(KIND_REMOVE, -32'sd1, 1'b0);
    // value extremes at both ends
    send_command(KIND_APPEND, 32'sh7FFF_FFFF, 1'b0);
    send_command(KIND_APPEND, 32'sh8000_0000, 1'b1);
    send_command(KIND_HEAD, 32'sd0, 1'b0);
    send_command(KIND_HEAD, -32'sd1, 1'b1);
    send_command(KIND_APPEND, 32'sd1, 1'b0);
    send_command(KIND_READ, $urandom, 1'b0);
    send_command(KIND_READ, $urandom, 1'b1);
    send_command(KIND_SEARCH, 32'sh8000_0000, 1'b0);
    send_command(KIND_SEARCH, 32'sd5, 1'b0);
    send_command(KIND_REMOVE, 32'sd0, 1'b1);
    send_command(KIND_REMOVE, 32'sd5, 1'b0);
    // unused kinds
    send_command(3'd5, $urandom, 1'b1);
    send_command(3'd6, $urandom, 1'b0);
    send_command(3'd7, $urandom, 1'b1);
    // fill up, then hit the full list from both ends
    for (n = 0; n < Capacity - 4; n++)
      send_command(n[0] ? KIND_HEAD : KIND_APPEND, $urandom, n[1]);
    send_command(KIND_APPEND, $urandom, 1'b0);
    send_command(KIND_HEAD, $urandom, 1'b1);
    send_command(KIND_READ, $urandom, 1'b1);

    for (n = 0; n < RandomItems; n++) begin
      no_idle = (n % 80) < 15;
      r = $urandom_range(0, 99);
      if ((n / 40) % 2 == 0) begin
        if (r < 35) k = KIND_APPEND;
        else if (r < 60) k = KIND_HEAD;
        else if (r < 70) k = KIND_SEARCH;
        else if (r < 80) k = KIND_REMOVE;
        else if (r < 96) k = KIND_READ;
        else k = 3'($urandom_range(5, 7));
      end else begin
        if (r < 10) k = KIND_APPEND;
        else if (r < 20) k = KIND_HEAD;
        else if (r < 35) k = KIND_SEARCH;
        else if (r < 80) k = KIND_REMOVE;
        else if (r < 95) k = KIND_READ;
        else k = 3'($urandom_range(5, 7));
      end
      r = $urandom_range(0, 7);
      if ((k == KIND_SEARCH || k == KIND_REMOVE) && board.fill > 0 && r < 6) begin
        v = board.cells[$urandom_range(0, board.fill - 1)];
      end else if (r < 4) begin
        case ($urandom_range(0, 5))
          0: v = 32'sd0;
          1: v = -32'sd1;
          2: v = 32'sh8000_0000;
          3: v = 32'sh7FFF_FFFF;
          4: v = 32'sd42;
          default: v = 32'sh5555_5555;
        endcase
      end else begin
        v = $urandom;
      end
      send_command(k, v, 1'($urandom_range(0, 1)));
    end
    in_valid = 1'b0;
    no_idle = 1'b0;

    while (board.pending() != 0) @(posedge clk_i);
    repeat (TailCycles) @(posedge clk_i);

    $display("Covered %0d commands and %0d result beats: %0d read-outs, %0d full rejects,",
             board.commands_seen, board.beats_checked, board.read_outs, board.full_rejects);
    $display("peak %0d entries; mismatches: %0d, results still outstanding: %0d.",
             board.peak_fill, board.mismatches, board.pending());
    if (board.mismatches == 0 && board.pending() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end
endmodule

// ----- sim.f -----
rtl/ole_pkg.sv
rtl/ole_cell.sv
rtl/ordered_list_engine_unit.sv
test/testbench.sv
